>>> rtl/hcdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcdq_pkg
// Shared types, constants and small tables for the chroma dequant,
// 4x4 inverse transform and reconstruction block.
// ----------------------------------------------------------------------------
package hcdq_pkg;

    // field widths
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 26;
    localparam int WIDE_W  = 40;
    localparam int PRED_W  = 8;
    localparam int POS_W   = 4;
    localparam int QPH_W   = 4;
    localparam int QPL_W   = 3;
    localparam int BLK     = 16;

    // dequant constants
    localparam logic [QPH_W-1:0] QP_SHIFT_PIVOT = 4'd5;
    localparam logic signed [DATA_W-1:0] CLIP10_MAX = 16'sd511;
    localparam logic signed [DATA_W-1:0] CLIP10_MIN = -16'sd512;

    // transform shifts
    localparam int VERT_SHIFT  = 7;
    localparam int HORIZ_SHIFT = 12;

    // configuration register indexes
    localparam logic CFG_QP_HIGH = 1'b0;
    localparam logic CFG_QP_LOW  = 1'b1;

    // control toward the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;    // load rounding constant into accumulator
        logic acc;    // add last product into accumulator
        logic horiz;  // horizontal pass rounding
    } t_mac_ctl;

    // level scale for qp modulo six, codes above five reuse the top entry
    function automatic logic [6:0] level_scale(input logic [QPL_W-1:0] sel);
        logic [6:0] v;
        case (sel)
            3'd0:    v = 7'd40;
            3'd1:    v = 7'd45;
            3'd2:    v = 7'd51;
            3'd3:    v = 7'd57;
            3'd4:    v = 7'd64;
            default: v = 7'd72;
        endcase
        return v;
    endfunction

    // 4-point inverse transform matrix, output k by input tap j
    function automatic logic signed [7:0] idct_coef(input logic [1:0] k,
                                                    input logic [1:0] j);
        logic signed [7:0] v;
        unique case ({k, j})
            4'h0, 4'h2, 4'h4, 4'h8, 4'hc, 4'he: v = 8'sd64;
            4'h6, 4'ha:                         v = -8'sd64;
            4'h1, 4'hb:                         v = 8'sd83;
            4'h7, 4'hd:                         v = -8'sd83;
            4'h3, 4'h5:                         v = 8'sd36;
            4'h9, 4'hf:                         v = -8'sd36;
            default:                            v = 8'sd0;
        endcase
        return v;
    endfunction

    // saturate a wide signed value to 16 bits
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [WIDE_W-1:0] x);
        logic signed [DATA_W-1:0] v;
        if (x > 40'sd32767) begin
            v = 16'sh7fff;
        end else if (x < -40'sd32768) begin
            v = 16'sh8000;
        end else begin
            v = x[DATA_W-1:0];
        end
        return v;
    endfunction

endpackage

>>> rtl/hcdq_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcdq_mac
// Shared signed 16x16 multiplier with a registered product and a
// rounding-preloaded accumulator, used for dequant and both transform passes.
// ----------------------------------------------------------------------------
module hcdq_mac
    import hcdq_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_prod,
    output logic signed [ACC_W-1:0]  o_sum
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_rnd;

    // rounding constant for the pass in progress
    assign w_rnd = i_ctl.horiz ? (ACC_W'(1) <<< (HORIZ_SHIFT - 1))
                               : (ACC_W'(1) <<< (VERT_SHIFT - 1));

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= w_rnd;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + r_prod[ACC_W-1:0];
        end
    end

    assign o_prod = r_prod;
    assign o_sum  = r_acc + r_prod[ACC_W-1:0];

endmodule

>>> rtl/hevc_chroma_dequant_idct4_recon_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_chroma_dequant_idct4_recon_top
// Chroma 4x4 dequantization, vertical and horizontal inverse transform and
// reconstruction, built around one shared multiply-accumulate unit.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_ready| i_coef, i_weight, i_pred
//  output   | out       | o_out_valid/i_out_ready| o_recon, o_position, o_last
//  config   | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
//  each load passes the weight scale, coefficient product and shift steps
//  through the shared multiplier; ready is low meanwhile
//  after the sixteenth load the vertical pass computes all sixteen mid
//  values, then each output sample runs its horizontal taps and is held
//  for its transfer; every step shares the single multiplier
//  a stall on the output channel holds the sequencer on the pending sample
//  reset is synchronous active low; stores need no clearing
// ----------------------------------------------------------------------------
module hevc_chroma_dequant_idct4_recon_top
    import hcdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic [PRED_W-1:0]        i_pred,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [PRED_W-1:0]        o_recon,
    output logic [POS_W-1:0]         o_position,
    output logic                     o_last,
    // configuration
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [QPH_W-1:0]         i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCALE = 9'b000000010,
        S_PROD  = 9'b000000100,
        S_SHIFT = 9'b000001000,
        S_VMAC  = 9'b000010000,
        S_VEND  = 9'b000100000,
        S_HMAC  = 9'b001000000,
        S_HEND  = 9'b010000000,
        S_OWAIT = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [QPH_W-1:0] r_qp_high;
    logic [QPL_W-1:0] r_qp_low;
    logic [POS_W-1:0] r_load_count, n_load_count;
    logic [1:0]       r_grp, n_grp;
    logic [1:0]       r_k, n_k;
    logic [1:0]       r_tap, n_tap;

    logic signed [DATA_W-1:0] r_coef;
    logic signed [DATA_W-1:0] r_weight;

    logic signed [DATA_W-1:0] r_coef_store [BLK];
    logic signed [DATA_W-1:0] r_mid_store  [BLK];
    logic [PRED_W-1:0]        r_pred_store [BLK];

    logic              r_out_valid, n_out_valid;
    logic [PRED_W-1:0] r_recon;
    logic [POS_W-1:0]  r_position;
    logic              r_last;

    t_mac_ctl                 w_ctl;
    logic signed [DATA_W-1:0] w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_sum;

    logic                     w_in_xfer, w_out_xfer;
    logic                     w_qp_big;
    logic signed [DATA_W-1:0] w_coef_clip;
    logic signed [DATA_W-1:0] w_dq;
    logic signed [DATA_W-1:0] w_vert, w_horiz;
    logic [PRED_W-1:0]        w_recon;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = r_out_valid && i_out_ready;
    assign w_qp_big   = r_qp_high > QP_SHIFT_PIVOT;

    // shared multiply-accumulate unit
    hcdq_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod),
        .o_sum  (w_sum)
    );

    // coefficient clip for large qp
    always_comb begin
        w_coef_clip = r_coef;
        if (w_qp_big) begin
            if (r_coef > CLIP10_MAX) begin
                w_coef_clip = CLIP10_MAX;
            end else if (r_coef < CLIP10_MIN) begin
                w_coef_clip = CLIP10_MIN;
            end
        end
    end

    // multiplier operand and accumulator control
    always_comb begin
        w_mul_a   = r_weight;
        w_mul_b   = DATA_W'(level_scale(r_qp_low));
        w_ctl.clr   = 1'b0;
        w_ctl.acc   = 1'b0;
        w_ctl.horiz = 1'b0;
        unique case (r_state)
            S_PROD: begin
                w_mul_a = w_coef_clip;
                w_mul_b = w_prod[DATA_W-1:0];
            end
            S_VMAC: begin
                w_mul_a   = r_coef_store[{r_tap, r_grp}];
                w_mul_b   = DATA_W'(idct_coef(r_k, r_tap));
                w_ctl.clr = (r_tap == 2'd0);
                w_ctl.acc = (r_tap != 2'd0);
            end
            S_HMAC: begin
                w_mul_a     = r_mid_store[{r_grp, r_tap}];
                w_mul_b     = DATA_W'(idct_coef(r_k, r_tap));
                w_ctl.clr   = (r_tap == 2'd0);
                w_ctl.acc   = (r_tap != 2'd0);
                w_ctl.horiz = 1'b1;
            end
            S_HEND: begin
                w_ctl.horiz = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // dequant shift and saturation
    always_comb begin
        logic signed [WIDE_W-1:0]   wide;
        logic signed [PROD_W:0]     rsum;
        logic [QPH_W-1:0]           sh;
        wide = WIDE_W'(w_prod);
        rsum = (PROD_W + 1)'(w_prod);
        sh   = 4'd0;
        if (w_qp_big) begin
            sh   = r_qp_high - QP_SHIFT_PIVOT;
            wide = wide <<< sh;
        end else begin
            sh = QP_SHIFT_PIVOT - r_qp_high;
            if (r_qp_high < QP_SHIFT_PIVOT) begin
                rsum = rsum + ((PROD_W + 1)'(1) <<< (sh - 4'd1));
            end
            rsum = rsum >>> sh;
            wide = WIDE_W'(rsum);
        end
        w_dq = sat16(wide);
    end

    // transform pass outputs and reconstruction
    always_comb begin
        logic signed [ACC_W-1:0] vs, hs;
        logic signed [17:0]      sum;
        vs      = w_sum >>> VERT_SHIFT;
        hs      = w_sum >>> HORIZ_SHIFT;
        w_vert  = sat16(WIDE_W'(vs));
        w_horiz = sat16(WIDE_W'(hs));
        sum     = $signed({10'd0, r_pred_store[{r_grp, r_k}]}) + 18'(w_horiz);
        if (sum < 18'sd0) begin
            w_recon = 8'd0;
        end else if (sum > 18'sd255) begin
            w_recon = 8'd255;
        end else begin
            w_recon = sum[PRED_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_grp        = r_grp;
        n_k          = r_k;
        n_tap        = r_tap;
        n_out_valid  = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_PROD;
            end
            S_PROD: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                n_load_count = r_load_count + 4'd1;
                n_grp        = 2'd0;
                n_k          = 2'd0;
                n_tap        = 2'd0;
                n_state      = (r_load_count == 4'd15) ? S_VMAC : S_IDLE;
            end
            S_VMAC: begin
                n_tap = r_tap + 2'd1;
                if (r_tap == 2'd3) begin
                    n_state = S_VEND;
                end
            end
            S_VEND: begin
                n_k     = r_k + 2'd1;
                n_state = S_VMAC;
                if (r_k == 2'd3) begin
                    n_grp = r_grp + 2'd1;
                    if (r_grp == 2'd3) begin
                        n_state = S_HMAC;
                    end
                end
            end
            S_HMAC: begin
                n_tap = r_tap + 2'd1;
                if (r_tap == 2'd3) begin
                    n_state = S_HEND;
                end
            end
            S_HEND: begin
                n_out_valid = 1'b1;
                n_state     = S_OWAIT;
            end
            S_OWAIT: begin
                if (w_out_xfer) begin
                    n_out_valid = 1'b0;
                    n_k         = r_k + 2'd1;
                    n_state     = S_HMAC;
                    if (r_k == 2'd3) begin
                        n_grp = r_grp + 2'd1;
                        if (r_grp == 2'd3) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_load_count <= '0;
            r_grp        <= '0;
            r_k          <= '0;
            r_tap        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_grp        <= n_grp;
            r_k          <= n_k;
            r_tap        <= n_tap;
            r_out_valid  <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qp_high <= '0;
            r_qp_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QP_HIGH: r_qp_high <= i_cfg_data;
                CFG_QP_LOW:  r_qp_low  <= i_cfg_data[QPL_W-1:0];
                default:     r_qp_low  <= r_qp_low;
            endcase
        end
    end

    // input capture and stores
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_coef                     <= i_coef;
            r_weight                   <= i_weight;
            r_pred_store[r_load_count] <= i_pred;
        end
        if (r_state == S_SHIFT) begin
            r_coef_store[r_load_count] <= w_dq;
        end
        if (r_state == S_VEND) begin
            r_mid_store[{r_k, r_grp}] <= w_vert;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (r_state == S_HEND) begin
            r_recon    <= w_recon;
            r_position <= {r_grp, r_k};
            r_last     <= (r_grp == 2'd3) && (r_k == 2'd3);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_recon     = r_recon;
    assign o_position  = r_position;
    assign o_last      = r_last;

endmodule

>>> sim/hevc_chroma_dequant_idct4_recon_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_chroma_dequant_idct4_recon_top_tb
// Loads 4x4 chroma blocks of coefficient, weight and prediction triples and
// checks every reconstructed sample against a behavioral dequant, inverse
// transform and reconstruction model run on each accepted load. Covers
// extreme field values, random quantizer settings including out-of-range codes,
// settings changed in the middle of a block, bursty input, output stalls and
// one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module hevc_chroma_dequant_idct4_recon_top_tb;
    import hcdq_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 11;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 4000;
    localparam int LOAD_TARGET   = 430;
    localparam int MAX_ERR_LINES = 100;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] weight;
        logic [PRED_W-1:0]        pred;
    } t_load;

    typedef struct packed {
        logic [PRED_W-1:0] recon;
        logic [POS_W-1:0]  position;
        logic              last;
    } t_recon;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_coef;
    logic signed [DATA_W-1:0] i_weight;
    logic [PRED_W-1:0]        i_pred;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [PRED_W-1:0]        o_recon;
    logic [POS_W-1:0]         o_position;
    logic                     o_last;
    logic                     i_cfg_we;
    logic                     i_cfg_idx;
    logic [QPH_W-1:0]         i_cfg_data;

    hevc_chroma_dequant_idct4_recon_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_coef      (i_coef),
        .i_weight    (i_weight),
        .i_pred      (i_pred),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_recon     (o_recon),
        .o_position  (o_position),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // loads waiting for the driver, samples waiting for the block
    t_load  load_q[$];
    t_recon recon_q[$];

    // model copy of the quantizer settings and block stores
    logic [QPH_W-1:0]  qp_high_m;
    logic [QPL_W-1:0]  qp_low_m;
    longint            dq_buf[BLK];
    logic [PRED_W-1:0] pred_buf[BLK];
    longint            mid_buf[BLK];
    logic [POS_W-1:0]  load_pos;

    int     err_count;
    int     idle_cycles;
    logic   in_taken;
    int     tx_gap_left;
    int     tx_burst_left;
    logic   tx_bursty;
    int     rx_mode;
    logic   rx_hold_req;
    int     rx_hold_left;
    int     rx_tick;
    t_load  tx_item;
    t_recon got_s;
    t_recon exp_s;

    // directed block at reset settings: field extremes
    logic signed [DATA_W-1:0] dir_coef [16] = '{
        16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd511, -16'sd512, 16'sd512,
        -16'sd513, 16'sd100, -16'sd100, 16'sh7fff, 16'sh8000, 16'sd7, -16'sd7, 16'sd0};
    logic signed [DATA_W-1:0] dir_weight [16] = '{
        16'sh7fff, 16'sh8000, 16'sd1, -16'sd1, 16'sd0, 16'sd16, 16'sd910, -16'sd911,
        16'sd40, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd1, 16'sd64, -16'sd64, 16'sd0};
    // directed half block at the top settings
    logic signed [DATA_W-1:0] top_coef [8] = '{
        16'sh8000, 16'sh7fff, 16'sd511, -16'sd512, -16'sd1, 16'sd1, 16'sd0, 16'sd300};
    logic signed [DATA_W-1:0] top_weight [8] = '{
        16'sh7fff, 16'sh8000, 16'sd1, -16'sd1, 16'sd50, -16'sd50, 16'sd0, 16'sd910};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // model arithmetic
    // ------------------------------------------------------------------

    function automatic longint clip16(input longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint scale_of(input logic [QPL_W-1:0] sel);
        case (sel)
            3'd0:    return 40;
            3'd1:    return 45;
            3'd2:    return 51;
            3'd3:    return 57;
            3'd4:    return 64;
            default: return 72;
        endcase
    endfunction

    // clip, scale by truncated weight, round and shift, saturate
    function automatic longint dequant_coef(input logic signed [DATA_W-1:0] c,
                                            input logic signed [DATA_W-1:0] w);
        longint                   cv;
        longint                   wprod;
        logic signed [DATA_W-1:0] w16;
        longint                   wv;
        longint                   p;
        longint                   v;
        longint                   rnd;
        int                       qh;
        cv    = c;
        wprod = longint'(w) * scale_of(qp_low_m);
        w16   = wprod[DATA_W-1:0];
        wv    = w16;
        qh    = int'(qp_high_m);
        if (qh > 5) begin
            if (cv > 511) cv = 511;
            if (cv < -512) cv = -512;
        end
        p = cv * wv;
        if (qh > 5) begin
            v = p <<< (qh - 5);
        end else begin
            rnd = (qh < 5) ? (longint'(1) << (4 - qh)) : 0;
            v   = (p + rnd) >>> (5 - qh);
        end
        return clip16(v);
    endfunction

    // 4-point inverse transform with rounding shift and saturation
    function automatic void butterfly4(input longint a0, input longint a1,
                                       input longint a2, input longint a3,
                                       input int sh,
                                       output longint r0, output longint r1,
                                       output longint r2, output longint r3);
        longint e0;
        longint e1;
        longint o0;
        longint o1;
        longint rnd;
        e0  = 64 * (a0 + a2);
        e1  = 64 * (a0 - a2);
        o0  = 83 * a1 + 36 * a3;
        o1  = 36 * a1 - 83 * a3;
        rnd = longint'(1) << (sh - 1);
        r0  = clip16((e0 + o0 + rnd) >>> sh);
        r1  = clip16((e1 + o1 + rnd) >>> sh);
        r2  = clip16((e1 - o1 + rnd) >>> sh);
        r3  = clip16((e0 - o0 + rnd) >>> sh);
    endfunction

    // store one load; on the sixteenth, queue the whole reconstructed block
    task automatic load_and_predict(input t_load ld);
        longint r0;
        longint r1;
        longint r2;
        longint r3;
        longint v;
        t_recon s;
        dq_buf[load_pos]   = dequant_coef(ld.coef, ld.weight);
        pred_buf[load_pos] = ld.pred;
        if (load_pos == POS_W'(BLK - 1)) begin
            // vertical pass, column by column
            for (int i = 0; i < 4; i++) begin
                butterfly4(dq_buf[i], dq_buf[4 + i], dq_buf[8 + i], dq_buf[12 + i],
                           VERT_SHIFT, r0, r1, r2, r3);
                mid_buf[i]      = r0;
                mid_buf[4 + i]  = r1;
                mid_buf[8 + i]  = r2;
                mid_buf[12 + i] = r3;
            end
            // horizontal pass and prediction add
            for (int i = 0; i < 4; i++) begin
                butterfly4(mid_buf[4 * i], mid_buf[4 * i + 1], mid_buf[4 * i + 2],
                           mid_buf[4 * i + 3], HORIZ_SHIFT, r0, r1, r2, r3);
                for (int k = 0; k < 4; k++) begin
                    case (k)
                        0:       v = r0;
                        1:       v = r1;
                        2:       v = r2;
                        default: v = r3;
                    endcase
                    v = v + longint'(pred_buf[4 * i + k]);
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    s.recon    = PRED_W'(v);
                    s.position = POS_W'(4 * i + k);
                    s.last     = (4 * i + k == BLK - 1);
                    recon_q.push_back(s);
                end
            end
        end
        load_pos = load_pos + POS_W'(1);
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        err_count++;
        if (err_count <= MAX_ERR_LINES)
            $display("ERROR at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // monitor: settings, input transfers, output checks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_QP_HIGH)
                    qp_high_m = i_cfg_data;
                else
                    qp_low_m = i_cfg_data[QPL_W-1:0];
            end
            if (i_in_valid && o_in_ready) begin
                tx_item.coef   = i_coef;
                tx_item.weight = i_weight;
                tx_item.pred   = i_pred;
                load_and_predict(tx_item);
            end
            if (o_out_valid && i_out_ready) begin
                got_s.recon    = o_recon;
                got_s.position = o_position;
                got_s.last     = o_last;
                if (recon_q.size() == 0) begin
                    report_mismatch("sample with none pending, position", -1,
                                    int'(got_s.position));
                end else begin
                    exp_s = recon_q.pop_front();
                    if (got_s.recon !== exp_s.recon)
                        report_mismatch("recon", int'(exp_s.recon), int'(got_s.recon));
                    if (got_s.position !== exp_s.position)
                        report_mismatch("position", int'(exp_s.position),
                                        int'(got_s.position));
                    if (got_s.last !== exp_s.last)
                        report_mismatch("last", int'(exp_s.last), int'(got_s.last));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STUCK_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("hevc_chroma_dequant_idct4_recon_top_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // input driver: bursts with random gaps
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold the offered load until its transfer
        end else if (tx_gap_left > 0) begin
            i_in_valid <= 1'b0;
            tx_gap_left = tx_gap_left - 1;
        end else if (load_q.size() > 0) begin
            tx_item = load_q.pop_front();
            i_coef     <= tx_item.coef;
            i_weight   <= tx_item.weight;
            i_pred     <= tx_item.pred;
            i_in_valid <= 1'b1;
            tx_burst_left = tx_burst_left - 1;
            if (tx_burst_left <= 0) begin
                tx_burst_left = $urandom_range(1, 12);
                tx_gap_left   = tx_bursty ? $urandom_range(1, 8) : 0;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // output receiver: stall pattern plus optional long hold-off
    always @(negedge i_clk) begin
        rx_tick = rx_tick + 1;
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic write_reg(input logic idx, input logic [QPH_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic push_load(input logic signed [DATA_W-1:0] c,
                             input logic signed [DATA_W-1:0] w,
                             input logic [PRED_W-1:0] p);
        t_load ld;
        ld.coef   = c;
        ld.weight = w;
        ld.pred   = p;
        load_q.push_back(ld);
    endtask

    // wait until every load is taken and every sample checked, then let
    // any load still inside the block finish
    task automatic wait_drained();
        @(posedge i_clk);
        while (load_q.size() != 0 || i_in_valid || recon_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_random_load();
        int cv;
        int wv;
        int pv;
        int sel;
        sel = $urandom_range(0, 5);
        if (sel <= 2) begin
            cv = int'($urandom_range(0, 511)) - 256;
        end else if (sel == 3) begin
            cv = $urandom;
        end else begin
            case ($urandom_range(0, 5))
                0:       cv = 32767;
                1:       cv = -32768;
                2:       cv = 511;
                3:       cv = -512;
                4:       cv = 512;
                default: cv = -513;
            endcase
        end
        sel = $urandom_range(0, 5);
        if (sel <= 2) begin
            wv = int'($urandom_range(0, 160)) - 80;
        end else if (sel == 3) begin
            wv = $urandom;
        end else begin
            case ($urandom_range(0, 5))
                0:       wv = 32767;
                1:       wv = -32768;
                2:       wv = 0;
                3:       wv = 1;
                4:       wv = -1;
                default: wv = 911;
            endcase
        end
        sel = $urandom_range(0, 9);
        if (sel <= 7)
            pv = $urandom_range(0, 255);
        else
            pv = (sel == 8) ? 0 : 255;
        push_load(DATA_W'(cv), DATA_W'(wv), PRED_W'(pv));
    endtask

    initial begin
        int n_loads;
        int n_phase;
        int phase;
        logic [QPH_W-1:0] qh;
        logic [QPH_W-1:0] ql;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_coef        = '0;
        i_weight      = '0;
        i_pred        = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_QP_HIGH;
        i_cfg_data    = '0;
        qp_high_m     = '0;
        qp_low_m      = '0;
        load_pos      = '0;
        err_count     = 0;
        idle_cycles   = 0;
        in_taken      = 1'b0;
        tx_gap_left   = 0;
        tx_burst_left = 1;
        tx_bursty     = 1'b0;
        rx_mode       = 0;
        rx_hold_req   = 1'b0;
        rx_hold_left  = 0;
        rx_tick       = 0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full block at reset settings, no idling on either side
        for (int k = 0; k < 16; k++)
            push_load(dir_coef[k], dir_weight[k], (k % 2 == 0) ? 8'd0 : 8'd255);
        wait_drained();

        // half a block at the top settings; the rest arrives under new settings
        write_reg(CFG_QP_HIGH, 4'd15);
        write_reg(CFG_QP_LOW, 4'd7);
        @(posedge i_clk);
        for (int k = 0; k < 8; k++)
            push_load(top_coef[k], top_weight[k], (k % 2 == 0) ? 8'd255 : 8'd0);
        wait_drained();
        n_loads = 24;

        // random phases, settings change between them
        phase = 0;
        while (n_loads < LOAD_TARGET) begin
            case (phase)
                0: begin qh = 4'd10; ql = 4'd5; end
                1: begin qh = 4'd5;  ql = 4'd6; end
                2: begin qh = 4'd6;  ql = 4'd0; end
                3: begin qh = 4'd0;  ql = 4'd5; end
                default: begin
                    qh = ($urandom_range(0, 4) == 0) ? QPH_W'($urandom_range(11, 15))
                                                     : QPH_W'($urandom_range(0, 10));
                    ql = QPH_W'($urandom_range(0, 7));
                end
            endcase
            write_reg(CFG_QP_HIGH, qh);
            write_reg(CFG_QP_LOW, ql);
            @(posedge i_clk);
            if (phase == 2)
                n_phase = 48;
            else if ($urandom_range(0, 3) == 0)
                n_phase = $urandom_range(1, 40);
            else
                n_phase = 16;
            tx_bursty = ($urandom_range(0, 3) != 0);
            rx_mode   = $urandom_range(0, 3);
            // long output hold-off while loads keep coming
            if (phase == 2)
                rx_hold_req = 1'b1;
            for (int k = 0; k < n_phase; k++)
                push_random_load();
            n_loads = n_loads + n_phase;
            wait_drained();
            phase++;
        end

        wait_drained();
        if (err_count == 0)
            $display("hevc_chroma_dequant_idct4_recon_top_tb passed");
        else
            $display("hevc_chroma_dequant_idct4_recon_top_tb failed");
        $finish;
    end

endmodule

>>> hevc_chroma_dequant_idct4_recon_top.f
rtl/hcdq_pkg.sv
rtl/hcdq_mac.sv
rtl/hevc_chroma_dequant_idct4_recon_top.sv
sim/hevc_chroma_dequant_idct4_recon_top_tb.sv
